// File: hdl/lpedq_pkg.sv
// ----------------------------------------------------------------------------
// lpedq_pkg
// Shared types and constants for the LED pixel error diffusion quantizer.
// ----------------------------------------------------------------------------
package lpedq_pkg;

    localparam int FRAC_BITS_DEF = 16;   // default fraction bits of a component
    localparam int MAX_CHANNELS  = 4;    // samples per pixel at most
    localparam int NUM_COMP      = 4;    // components per pixel
    localparam int IDX_W         = 2;    // index into the components
    localparam int COMP_W        = 20;   // component width, signed
    localparam int SAMPLE_W      = 16;   // sample width
    localparam int CNT_W         = 3;    // channel count register width
    localparam int RANGE_W       = 17;   // sample range as a signed operand
    localparam int RANGE_NARROW  = 255;
    localparam int RANGE_WIDE    = 65535;
    localparam int ERR_MAX_LSB   = 32767; // error limit in sample LSB

    // divider: quotient magnitude fits in a component, two bits per cycle
    localparam int DIV_BITS   = COMP_W;
    localparam int DIV_CYCLES = DIV_BITS / 2;
    localparam int DCNT_W     = $clog2(DIV_CYCLES);

    // APB register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_CHANNEL_COUNT  = 3'd0,
        REG_CHANNEL_FIRST  = 3'd1,
        REG_CHANNEL_SECOND = 3'd2,
        REG_CHANNEL_THIRD  = 3'd3,
        REG_CHANNEL_FOURTH = 3'd4,
        REG_WIDE_SAMPLES   = 3'd5
    } reg_idx_t;

    localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT  = 3'd3;
    localparam logic [IDX_W-1:0] RST_CHANNEL_FIRST  = 2'd0;
    localparam logic [IDX_W-1:0] RST_CHANNEL_SECOND = 2'd1;
    localparam logic [IDX_W-1:0] RST_CHANNEL_THIRD  = 2'd2;
    localparam logic [IDX_W-1:0] RST_CHANNEL_FOURTH = 2'd3;
    localparam logic             RST_WIDE_SAMPLES   = 1'b0;

    typedef struct packed {
        logic [CNT_W-1:0]                channel_count;
        logic [NUM_COMP-1:0][IDX_W-1:0]  channel_sel;   // [0] first .. [3] fourth
        logic                            wide_samples;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAX,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_QNT,
        ST_ERR,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic             take;       // latch input item
        logic             find_max;   // register max and normalize flag
        logic             div_load;   // load divider with current component
        logic             div_step;   // two quotient bits
        logic             mul;        // n * range
        logic             sum;        // + carried error
        logic             quant;      // clamp and round
        logic             err_wr;     // new carried error
        logic [IDX_W-1:0] comp;       // component being worked
        logic             push;       // load output register
        logic [IDX_W-1:0] slot;       // emit slot
        logic             last;       // last sample of pixel
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic norm;      // largest component above full scale
        logic out_free;  // output register can take an item
    } sts_t;

endpackage

// File: hdl/lpedq_regs.sv
// ----------------------------------------------------------------------------
// lpedq_regs
// APB configuration registers: channel count, channel order, sample width.
// ----------------------------------------------------------------------------
module lpedq_regs
    import lpedq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W-1:0] second_reg;
    logic [IDX_W-1:0] third_reg;
    logic [IDX_W-1:0] fourth_reg;
    logic             wide_reg;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= RST_CHANNEL_COUNT;
            first_reg  <= RST_CHANNEL_FIRST;
            second_reg <= RST_CHANNEL_SECOND;
            third_reg  <= RST_CHANNEL_THIRD;
            fourth_reg <= RST_CHANNEL_FOURTH;
            wide_reg   <= RST_WIDE_SAMPLES;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CHANNEL_COUNT:  count_reg  <= pwdata[CNT_W-1:0];
                REG_CHANNEL_FIRST:  first_reg  <= pwdata[IDX_W-1:0];
                REG_CHANNEL_SECOND: second_reg <= pwdata[IDX_W-1:0];
                REG_CHANNEL_THIRD:  third_reg  <= pwdata[IDX_W-1:0];
                REG_CHANNEL_FOURTH: fourth_reg <= pwdata[IDX_W-1:0];
                REG_WIDE_SAMPLES:   wide_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CHANNEL_COUNT:  prdata = DATA_W'(count_reg);
            REG_CHANNEL_FIRST:  prdata = DATA_W'(first_reg);
            REG_CHANNEL_SECOND: prdata = DATA_W'(second_reg);
            REG_CHANNEL_THIRD:  prdata = DATA_W'(third_reg);
            REG_CHANNEL_FOURTH: prdata = DATA_W'(fourth_reg);
            REG_WIDE_SAMPLES:   prdata = DATA_W'(wide_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.channel_count  = count_reg;
    assign cfg.channel_sel[0] = first_reg;
    assign cfg.channel_sel[1] = second_reg;
    assign cfg.channel_sel[2] = third_reg;
    assign cfg.channel_sel[3] = fourth_reg;
    assign cfg.wide_samples   = wide_reg;

endmodule

// File: hdl/lpedq_dp.sv
// ----------------------------------------------------------------------------
// lpedq_dp
// Datapath: max search, shared radix-4 divider, scale, error add, clamp and
// round, error update, sample store and output register.
// ----------------------------------------------------------------------------
module lpedq_dp
    import lpedq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic [NUM_COMP*COMP_W-1:0] s_tdata,
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [SAMPLE_W-1:0]        m_tdata,
    output logic                       m_tlast
);

    localparam int ERR_W  = FRAC_BITS + 16;
    localparam int PROD_W = COMP_W + RANGE_W;
    localparam int SUM_W  = ((PROD_W > ERR_W) ? PROD_W : ERR_W) + 1;
    localparam int DVD_W  = COMP_W + FRAC_BITS;
    localparam int REM_W  = COMP_W + 1;

    localparam logic signed [SUM_W-1:0] HALF     = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] TOP_NAR  = SUM_W'(RANGE_NARROW) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] TOP_WIDE = SUM_W'(RANGE_WIDE) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] ERR_LIM  = SUM_W'(ERR_MAX_LSB) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] ERR_NLIM = -ERR_LIM;
    localparam logic signed [31:0]      ONE32    = 32'sd1 <<< FRAC_BITS;

    logic signed [COMP_W-1:0]   comp_reg [NUM_COMP];
    logic signed [ERR_W-1:0]    err_reg  [NUM_COMP];
    logic [SAMPLE_W-1:0]        sample_reg [NUM_COMP];
    logic signed [COMP_W-1:0]   max_reg;
    logic                       norm_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [DIV_BITS-1:0]        dlow_reg;
    logic [DIV_BITS-1:0]        quo_reg;
    logic                       neg_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0]        q_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic                       out_last_reg;

    // max search
    logic signed [COMP_W-1:0] m01, m23, max_c;
    logic signed [31:0]       max_ext;

    always_comb
    begin
        m01     = (comp_reg[1] > comp_reg[0]) ? comp_reg[1] : comp_reg[0];
        m23     = (comp_reg[3] > comp_reg[2]) ? comp_reg[3] : comp_reg[2];
        max_c   = (m23 > m01) ? m23 : m01;
        max_ext = {{(32-COMP_W){max_c[COMP_W-1]}}, max_c};
    end

    // divider load and step
    logic signed [COMP_W-1:0] x_c;
    logic [COMP_W-1:0]        absx;
    logic [DVD_W-1:0]         dvd;
    logic [REM_W-1:0]         dv;
    logic [REM_W-1:0]         r1, r1b, r2, r2b;
    logic                     b1, b2;

    always_comb
    begin
        x_c  = comp_reg[cmd.comp];
        absx = x_c[COMP_W-1] ? (~x_c + COMP_W'(1)) : x_c;
        dvd  = {absx, {FRAC_BITS{1'b0}}};
        dv   = {1'b0, max_reg};
        r1   = {rem_reg[REM_W-2:0], dlow_reg[DIV_BITS-1]};
        b1   = (r1 >= dv);
        r1b  = b1 ? (r1 - dv) : r1;
        r2   = {r1b[REM_W-2:0], dlow_reg[DIV_BITS-2]};
        b2   = (r2 >= dv);
        r2b  = b2 ? (r2 - dv) : r2;
    end

    // scale, add, clamp, round, error
    logic signed [COMP_W-1:0]  quo_s, n_c;
    logic signed [PROD_W-1:0]  n_ext, rng_ext, prod_c;
    logic signed [SUM_W-1:0]   sum_c, top_c, rnd_c, q_ext, e_c, e_sat;
    logic [SAMPLE_W-1:0]       q_c;

    always_comb
    begin
        quo_s   = $signed(quo_reg);
        n_c     = norm_reg ? (neg_reg ? -quo_s : quo_s) : comp_reg[cmd.comp];
        n_ext   = PROD_W'(n_c);
        rng_ext = cfg.wide_samples ? PROD_W'(RANGE_WIDE) : PROD_W'(RANGE_NARROW);
        prod_c  = n_ext * rng_ext;
        sum_c   = SUM_W'(prod_reg) + SUM_W'(err_reg[cmd.comp]);

        top_c   = cfg.wide_samples ? TOP_WIDE : TOP_NAR;
        rnd_c   = sum_reg + HALF;
        if (sum_reg < 0)
            q_c = '0;
        else if (sum_reg > top_c)
            q_c = cfg.wide_samples ? SAMPLE_W'(RANGE_WIDE) : SAMPLE_W'(RANGE_NARROW);
        else
            q_c = rnd_c[FRAC_BITS +: SAMPLE_W];

        q_ext = SUM_W'({1'b0, q_reg}) << FRAC_BITS;
        e_c   = sum_reg - q_ext;
        if (e_c > ERR_LIM)
            e_sat = ERR_LIM;
        else if (e_c < ERR_NLIM)
            e_sat = ERR_NLIM;
        else
            e_sat = e_c;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            for (int i = 0; i < NUM_COMP; i++)
                comp_reg[i] <= s_tdata[i*COMP_W +: COMP_W];
        end
        if (cmd.find_max)
            max_reg <= max_c;
        if (cmd.div_load)
        begin
            rem_reg  <= REM_W'(dvd >> DIV_BITS);
            dlow_reg <= dvd[DIV_BITS-1:0];
            quo_reg  <= '0;
            neg_reg  <= x_c[COMP_W-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= r2b;
            dlow_reg <= {dlow_reg[DIV_BITS-3:0], 2'b00};
            quo_reg  <= {quo_reg[DIV_BITS-3:0], b1, b2};
        end
        if (cmd.mul)
            prod_reg <= prod_c;
        if (cmd.sum)
            sum_reg <= sum_c;
        if (cmd.quant)
        begin
            q_reg                <= q_c;
            sample_reg[cmd.comp] <= q_c;
        end
        if (cmd.push)
        begin
            out_data_reg <= sample_reg[cfg.channel_sel[cmd.slot]];
            out_last_reg <= cmd.last;
        end
    end

    // control-side state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_COMP; i++)
                err_reg[i] <= '0;
        end
        else
        begin
            if (cmd.find_max)
                norm_reg <= (max_ext > ONE32);
            if (cmd.take && s_tuser)
            begin
                for (int i = 0; i < NUM_COMP; i++)
                    err_reg[i] <= '0;
            end
            else if (cmd.err_wr)
                err_reg[cmd.comp] <= ERR_W'(e_sat);
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.norm     = norm_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign m_tlast      = out_last_reg;

`ifndef NO_ASSERTIONS
    // narrow mode never produces a sample above one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.quant && !cfg.wide_samples |=> q_reg[SAMPLE_W-1:8] == '0)
        else $error("lpedq_dp: narrow sample exceeds 255");

    // written error stays within the saturation limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.err_wr && !cmd.take |=>
            (err_reg[$past(cmd.comp)] <= ERR_LIM) && (err_reg[$past(cmd.comp)] >= ERR_NLIM))
        else $error("lpedq_dp: carried error out of range");
`endif

endmodule

// File: hdl/lpedq_ctrl.sv
// ----------------------------------------------------------------------------
// lpedq_ctrl
// Sequencer: walks the four components through divide (when normalizing),
// scale, quantize and error update, then emits the configured channels.
// ----------------------------------------------------------------------------
module lpedq_ctrl
    import lpedq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] channel_count,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sts_t             sts,
    output cmd_t             cmd
);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  comp_reg, comp_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]  count_eff;
    logic              slot_last;

    assign count_eff = (channel_count > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                              : channel_count;
    assign slot_last = ({1'b0, slot_reg} + CNT_W'(1)) == count_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            comp_reg  <= '0;
            slot_reg  <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            slot_reg  <= slot_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        slot_next  = slot_reg;
        dcnt_next  = dcnt_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        cmd.slot   = slot_reg;
        s_tready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_MAX;
                end
            end
            ST_MAX:
            begin
                cmd.find_max = 1'b1;
                comp_next    = '0;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.norm)
                begin
                    cmd.div_load = 1'b1;
                    dcnt_next    = '0;
                    state_next   = ST_DIV;
                end
                else
                    state_next = ST_MUL;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_CYCLES - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_QNT;
            end
            ST_QNT:
            begin
                cmd.quant  = 1'b1;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.err_wr = 1'b1;
                if (comp_reg == IDX_W'(NUM_COMP - 1))
                begin
                    slot_next  = '0;
                    state_next = (count_eff == '0) ? ST_IDLE : ST_EMIT;
                end
                else
                begin
                    comp_next  = comp_reg + IDX_W'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.last = slot_last;
                    if (slot_last)
                        state_next = ST_IDLE;
                    else
                        slot_next = slot_reg + IDX_W'(1);
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    // an item is only pushed when the output register can hold it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> sts.out_free)
        else $error("lpedq_ctrl: push into a full output register");

    // the marked sample ends the pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push && cmd.last |=> state_reg == ST_IDLE)
        else $error("lpedq_ctrl: pixel not finished after last sample");

    // the divider only runs when normalizing
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> sts.norm)
        else $error("lpedq_ctrl: divide without normalization");
`endif

endmodule

// File: hdl/led_pixel_error_diffusion_quantizer.sv
// ----------------------------------------------------------------------------
// led_pixel_error_diffusion_quantizer: error diffusion dither for LED pixels
// Per pixel: accept, max, then for each of the four components load, scale,
// add, quantize and error, plus ten radix-4 divider steps per component when
// the largest component exceeds full scale; then one emitted sample per cycle
// while the output register is free. The next pixel is taken once the last
// sample is in the output register (or after errors when none are emitted).
// Async active-low reset: carried errors zero, registers 3,0,1,2,3,0.
// ----------------------------------------------------------------------------
module led_pixel_error_diffusion_quantizer
    import lpedq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF     // fraction bits, 8..24
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input pixel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [NUM_COMP*COMP_W-1:0] s_tdata,   // comp_red, comp_green, comp_blue, comp_extra
    input  logic                       s_tuser,   // first_pixel
    // output samples
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [SAMPLE_W-1:0]        m_tdata,   // sample
    output logic                       m_tlast,   // last_of_pixel
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // APB register file
    lpedq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: one pixel at a time. Components are processed one after
    // another through the shared divider (when normalizing) and the
    // scale/quantize stages; errors of all four are updated whether emitted or not.
    lpedq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .channel_count (cfg.channel_count),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    // Datapath. The output register decouples the sink: the next pixel is
    // accepted while the final sample of the previous one still waits.
    lpedq_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: test/led_pixel_error_diffusion_quantizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_pixel_error_diffusion_quantizer_test
// Self-checking bench for the LED pixel dither. Pixels go in on the slave
// stream, samples come out on the master stream, and registers are written
// over APB between phases. A scoreboard class predicts every sample from its
// own copy of the registers and carried errors and checks them in order.
// ----------------------------------------------------------------------------
module led_pixel_error_diffusion_quantizer_test;

    import lpedq_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int CYCLE_LIMIT   = 600000;  // run aborts past this
    localparam int SETTLE_CYCLES = 100;     // waits out the worst pixel after a drain
    localparam int HOLD_CYCLES   = 600;     // long receiver hold-off
    localparam int BATCH_ITEMS   = 50;      // random pixels per register set
    localparam int BATCHES       = 3;       // register sets per idle phase
    localparam int REPORT_CAP    = 50;      // mismatch lines printed at most

    // component indices for the channel order registers
    localparam int COMP_RED   = 0;
    localparam int COMP_GREEN = 1;
    localparam int COMP_BLUE  = 2;
    localparam int COMP_EXTRA = 3;

    // register slots past the map; writes there must be dropped
    localparam int REG_SPARE_A = 6;
    localparam int REG_SPARE_B = 7;

    // interesting component values, Q3.16
    localparam logic [COMP_W-1:0] C_ZERO = '0;
    localparam logic [COMP_W-1:0] C_NEG1 = '1;
    localparam logic [COMP_W-1:0] C_HALF = COMP_W'(32768);
    localparam logic [COMP_W-1:0] C_FULL = COMP_W'(65536);
    localparam logic [COMP_W-1:0] C_OVER = COMP_W'(65537);
    localparam logic [COMP_W-1:0] C_MAX  = COMP_W'(524287);
    localparam logic [COMP_W-1:0] C_MIN  = COMP_W'(-524288);

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } sample_item_t;

    // ------------------------------------------------------------------------
    // Scoreboard: register copy, carried errors, and the samples still owed
    // ------------------------------------------------------------------------
    class dither_checker;
        cfg_t         cfg;
        longint       err_acc [NUM_COMP];
        sample_item_t owed_samples [$];
        int           fails;

        function new();
            fails = 0;
            cfg.channel_count  = RST_CHANNEL_COUNT;
            cfg.channel_sel[0] = RST_CHANNEL_FIRST;
            cfg.channel_sel[1] = RST_CHANNEL_SECOND;
            cfg.channel_sel[2] = RST_CHANNEL_THIRD;
            cfg.channel_sel[3] = RST_CHANNEL_FOURTH;
            cfg.wide_samples   = RST_WIDE_SAMPLES;
            foreach (err_acc[i])
                err_acc[i] = 0;
        endfunction

        function int outstanding();
            return owed_samples.size();
        endfunction

        // unknown slots are ignored, values cut to the register width
        function void write_reg(int idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_CHANNEL_COUNT:  cfg.channel_count  = value[CNT_W-1:0];
                REG_CHANNEL_FIRST:  cfg.channel_sel[0] = value[IDX_W-1:0];
                REG_CHANNEL_SECOND: cfg.channel_sel[1] = value[IDX_W-1:0];
                REG_CHANNEL_THIRD:  cfg.channel_sel[2] = value[IDX_W-1:0];
                REG_CHANNEL_FOURTH: cfg.channel_sel[3] = value[IDX_W-1:0];
                REG_WIDE_SAMPLES:   cfg.wide_samples   = value[0];
                default: ;
            endcase
        endfunction

        // quantize one accepted pixel and queue the samples it emits
        function void take_pixel(logic first, logic [NUM_COMP*COMP_W-1:0] data);
            longint                   one, lim, full_range, peak, n, s, c, q;
            longint                   comp [NUM_COMP];
            logic [SAMPLE_W-1:0]      quant [NUM_COMP];
            logic signed [COMP_W-1:0] field;
            sample_item_t             item;
            int                       cnt;

            one        = longint'(1) <<< FRAC_BITS_DEF;
            lim        = longint'(ERR_MAX_LSB) * one;
            full_range = cfg.wide_samples ? RANGE_WIDE : RANGE_NARROW;

            if (first)
                foreach (err_acc[i])
                    err_acc[i] = 0;

            for (int i = 0; i < NUM_COMP; i++)
            begin
                field   = data[i*COMP_W +: COMP_W];
                comp[i] = field;
            end

            peak = comp[0];
            for (int i = 1; i < NUM_COMP; i++)
                if (comp[i] > peak)
                    peak = comp[i];

            for (int i = 0; i < NUM_COMP; i++)
            begin
                n = comp[i];
                if (peak > one)
                    n = (n * one) / peak;     // truncates toward zero
                s = n * full_range + err_acc[i];
                c = s;
                if (c < 0)
                    c = 0;
                if (c > full_range * one)
                    c = full_range * one;
                q = (c + (one >>> 1)) >>> FRAC_BITS_DEF;
                quant[i] = q[SAMPLE_W-1:0];
                s = s - q * one;
                if (s > lim)
                    s = lim;
                if (s < -lim)
                    s = -lim;
                err_acc[i] = s;
            end

            cnt = cfg.channel_count;
            if (cnt > MAX_CHANNELS)
                cnt = MAX_CHANNELS;
            for (int i = 0; i < cnt; i++)
            begin
                item.value = quant[cfg.channel_sel[i]];
                item.last  = (i == cnt - 1);
                owed_samples.push_back(item);
            end
        endfunction

        task report(string what, longint got, longint want);
            if (fails < REPORT_CAP)
                $display("ERROR %0t: %s got %0d, expected %0d", $realtime, what, got, want);
            fails++;
        endtask

        task check_sample(logic [SAMPLE_W-1:0] value, logic last);
            sample_item_t want;
            if (owed_samples.size() == 0)
            begin
                report("sample with none owed", value, -1);
                return;
            end
            want = owed_samples.pop_front();
            if (value !== want.value)
                report("sample", value, want.value);
            if (last !== want.last)
                report("tlast", last, want.last);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [NUM_COMP*COMP_W-1:0] s_tdata;   // comp_red, comp_green, comp_blue, comp_extra
    logic                       s_tuser;   // first_pixel
    logic                       m_tvalid;
    logic                       m_tready;
    logic [SAMPLE_W-1:0]        m_tdata;   // sample
    logic                       m_tlast;   // last_of_pixel
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    dither_checker quant_board;

    int src_idle_pct = 0;   // chance per cycle that the sender holds back
    int snk_idle_pct = 0;   // chance per cycle that the receiver stalls
    int hold_req     = 0;   // bumped by the stimulus to ask for a long stall
    int hold_seen    = 0;
    int hold_left    = 0;
    int cycle_count  = 0;

    led_pixel_error_diffusion_quantizer u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request. The hold is
    // counted here so the sender keeps pushing while the output backs up.
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Monitor: both handshakes are sampled at the rising edge. A pixel and
    // its own samples can never complete on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                quant_board.take_pixel(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                quant_board.check_sample(m_tdata, m_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: every task starts and ends on a falling edge
    // ------------------------------------------------------------------------

    // Offer one pixel and hold it until taken. Valid stays high into the
    // next pixel unless the sender decides to idle.
    task send_pixel(logic first, logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                    logic [COMP_W-1:0] b, logic [COMP_W-1:0] x);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {x, b, g, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Setup then access phase. The bus is left in the access state so that
    // writes can run back to back; load_config releases it.
    task apb_write(int idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready)
            quant_board.write_reg(idx, value);
        @(negedge clk);
    endtask

    // Random upper bits check that each register keeps only its own width.
    function logic [DATA_W-1:0] with_junk(int value, int width);
        return (DATA_W'($urandom) << width) | DATA_W'(value);
    endfunction

    task load_config(int cnt, int sel0, int sel1, int sel2, int sel3, int wide);
        apb_write(REG_CHANNEL_COUNT,  with_junk(cnt,  CNT_W));
        apb_write(REG_CHANNEL_FIRST,  with_junk(sel0, IDX_W));
        apb_write(REG_CHANNEL_SECOND, with_junk(sel1, IDX_W));
        apb_write(REG_CHANNEL_THIRD,  with_junk(sel2, IDX_W));
        apb_write(REG_CHANNEL_FOURTH, with_junk(sel3, IDX_W));
        apb_write(REG_WIDE_SAMPLES,   with_junk(wide, 1));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering, collect every owed sample, then give a pixel that emits
    // nothing (count of zero) time to finish before the registers change.
    task drain();
        s_tvalid <= 1'b0;
        while (quant_board.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Mostly in-range levels, with overdrive, negatives, raw noise and edges.
    function logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return COMP_W'($urandom_range(0, 65536));
            4:          return COMP_W'($urandom_range(65537, 524287));
            5:          return COMP_W'($urandom);
            6:          return COMP_W'(-int'($urandom_range(1, 524288)));
            7:
            begin
                case ($urandom_range(0, 6))
                    0:       return C_ZERO;
                    1:       return C_NEG1;
                    2:       return C_HALF;
                    3:       return C_FULL;
                    4:       return C_OVER;
                    5:       return C_MAX;
                    default: return C_MIN;
                endcase
            end
            default:    return COMP_W'($urandom_range(60000, 70000));
        endcase
    endfunction

    // Count of zero and counts past four are kept rare but present.
    function int rand_count();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(MAX_CHANNELS + 1, 7);
            default: return $urandom_range(1, MAX_CHANNELS);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quant_board = new();

        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed: reset register values, 8-bit, three channels ---
        send_pixel(1'b1, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
        send_pixel(1'b0, C_FULL, C_FULL, C_FULL, C_FULL);    // full scale, no divide
        send_pixel(1'b0, C_OVER, C_ZERO, C_NEG1, C_FULL);    // just over, divide
        send_pixel(1'b0, C_MAX, C_MIN, C_HALF, 20'd1);
        send_pixel(1'b0, C_MIN, C_MIN, C_MIN, C_MIN);        // clamp at zero
        send_pixel(1'b0, C_HALF, 20'd128, 20'd257, C_NEG1);  // rounding half up
        send_pixel(1'b0, 20'd100, 20'd100, 20'd100, 20'd100);
        send_pixel(1'b1, 20'd100, 20'd100, 20'd100, 20'd100); // strand restart
        drain();

        // writes past the register map are dropped
        apb_write(REG_SPARE_A, DATA_W'($urandom));
        apb_write(REG_SPARE_B, DATA_W'($urandom));
        // 16-bit, four channels in reverse order
        load_config(MAX_CHANNELS, COMP_EXTRA, COMP_BLUE, COMP_GREEN, COMP_RED, 1);
        send_pixel(1'b1, C_MIN, C_MIN, C_MAX, C_ZERO);
        send_pixel(1'b0, C_MIN, C_MIN, C_MIN, C_MIN);        // error saturates low
        send_pixel(1'b0, C_MIN, C_MIN, C_MIN, C_MIN);
        send_pixel(1'b0, C_FULL, C_ZERO, 20'd1, 20'd32767);
        send_pixel(1'b0, C_MAX, C_MAX, C_MAX, C_MAX);        // all equal overdrive
        drain();

        // count of zero: nothing comes out, errors still move
        load_config(0, COMP_BLUE, COMP_EXTRA, COMP_RED, COMP_GREEN, 0);
        send_pixel(1'b0, 20'd1000, C_MIN, C_OVER, 20'd5);
        send_pixel(1'b0, C_HALF, C_HALF, C_NEG1, C_FULL);
        drain();

        // one channel; the other components keep diffusing unseen
        load_config(1, COMP_BLUE, COMP_RED, COMP_RED, COMP_RED, 0);
        send_pixel(1'b0, 20'd300, 20'd700, 20'd129, C_ZERO);
        send_pixel(1'b0, 20'd300, 20'd700, 20'd129, C_ZERO);
        drain();

        // count above the maximum, one component repeated
        load_config(7, COMP_GREEN, COMP_GREEN, COMP_GREEN, COMP_GREEN, 1);
        send_pixel(1'b1, C_NEG1, C_HALF, C_ZERO, C_MAX);
        send_pixel(1'b0, 20'd12345, 20'd54321, C_OVER, C_MIN);
        send_pixel(1'b0, C_ZERO, C_FULL, C_ZERO, C_ZERO);
        drain();

        // --- random: three idle phases, several register sets each ---
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 36;
                    snk_idle_pct = 64;
                end
                1:
                begin
                    src_idle_pct = 64;
                    snk_idle_pct = 36;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int batch = 0; batch < BATCHES; batch++)
            begin
                load_config(rand_count(), $urandom_range(0, 3), $urandom_range(0, 3),
                            $urandom_range(0, 3), $urandom_range(0, 3),
                            $urandom_range(0, 1));
                // long output stall while pixels keep coming
                if (batch == 0 && phase != 1)
                    hold_req++;
                // strands of random length, each opened by a first pixel
                for (int k = 0; k < BATCH_ITEMS; k++)
                    send_pixel(k == 0 || $urandom_range(99) < 4,
                               rand_comp(), rand_comp(), rand_comp(), rand_comp());
                drain();
            end
        end

        if (quant_board.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: led_pixel_error_diffusion_quantizer.f
hdl/lpedq_pkg.sv
hdl/lpedq_regs.sv
hdl/lpedq_dp.sv
hdl/lpedq_ctrl.sv
hdl/led_pixel_error_diffusion_quantizer.sv
test/led_pixel_error_diffusion_quantizer_test.sv
